[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, skipped while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Same check with an explicit failure text.
`define ASSERT_CLK_MSG(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

[hw/rtl/aar_pkg.sv]
// Types and constants shared by the ARCNET ARP responder modules.
`timescale 1ns / 1ps

package aar_pkg;

    // Outcome codes carried on m_tuser
    localparam logic [1:0] ACT_IGNORE  = 2'd0;
    localparam logic [1:0] ACT_REPLY   = 2'd1;
    localparam logic [1:0] ACT_GATEWAY = 2'd2;

    // Configuration register indexes
    localparam logic CFG_MY_IP   = 1'b0;
    localparam logic CFG_NODE_ID = 1'b1;

    // Payload layout
    localparam logic [4:0] POS_SAT  = 5'd18;  // position saturates here
    localparam logic [4:0] POS_LAST = 5'd17;  // last target IP byte

    // Expected header bytes
    localparam logic [7:0] HTYPE_HI  = 8'h00;
    localparam logic [7:0] HTYPE_LO  = 8'h07;
    localparam logic [7:0] PTYPE_HI  = 8'h08;
    localparam logic [7:0] PTYPE_LO  = 8'h00;
    localparam logic [7:0] HLEN      = 8'h01;
    localparam logic [7:0] PLEN      = 8'h04;
    localparam logic [7:0] OPCODE_HI = 8'h00;

    // Opcode low bytes
    localparam logic [7:0] OP_REQUEST = 8'h01;
    localparam logic [7:0] OP_REPLY   = 8'h02;

    // One input word held in the input stage
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    // One result word
    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  reply_dest_node;
        logic [31:0] reply_target_ip;
        logic [7:0]  reply_sender_node;
        logic [7:0]  gateway_node;
        logic        gateway_known;
    } result_t;

endpackage

[hw/rtl/aar_in_stage.sv]
// Input register stage: holds one incoming word until the parser takes it.
`timescale 1ns / 1ps

module aar_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  aar_pkg::in_word_t in_word,
    output logic              out_valid,
    input  logic              out_pop,
    output aar_pkg::in_word_t out_word
);
    import aar_pkg::*;

    logic     valid_reg;
    in_word_t word_reg;

    // accept when empty or when the held word leaves this cycle
    assign in_ready  = !valid_reg || out_pop;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= in_word;
        end
    end

endmodule

[hw/rtl/aar_parser.sv]
// Packet parser: header checks, field capture, target compare and outcome.
`timescale 1ns / 1ps

module aar_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             take,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    input  logic [31:0]      my_ip,
    input  logic [7:0]       node_id,
    output aar_pkg::result_t result
);
    import aar_pkg::*;

    logic [4:0]  pos_reg,    pos_next;
    logic        hdr_ok_reg, hdr_ok_next;
    logic        tgt_ok_reg, tgt_ok_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [7:0]  snode_reg,  snode_next;
    logic [31:0] saddr_reg,  saddr_next;
    logic [7:0]  gw_reg,     gw_next;

    logic        hdr_ok_eff;
    logic        tgt_ok_eff;
    logic [7:0]  opcode_eff;
    logic [7:0]  snode_eff;
    logic [31:0] saddr_eff;
    logic [7:0]  ip_byte;
    logic [1:0]  ip_idx;
    logic        qualify;
    logic        learn;

    // which octet of our address the current target byte is compared with
    assign ip_idx = pos_reg[1:0] - 2'd2;

    always_comb begin
        unique case (ip_idx)
            2'd0:    ip_byte = my_ip[31:24];
            2'd1:    ip_byte = my_ip[23:16];
            2'd2:    ip_byte = my_ip[15:8];
            default: ip_byte = my_ip[7:0];
        endcase
    end

    // state as it stands after this byte
    always_comb begin
        hdr_ok_eff = hdr_ok_reg;
        tgt_ok_eff = tgt_ok_reg;
        opcode_eff = opcode_reg;
        snode_eff  = snode_reg;
        saddr_eff  = saddr_reg;
        unique case (pos_reg)
            5'd0:  hdr_ok_eff = hdr_ok_reg && (data_byte == HTYPE_HI);
            5'd1:  hdr_ok_eff = hdr_ok_reg && (data_byte == HTYPE_LO);
            5'd2:  hdr_ok_eff = hdr_ok_reg && (data_byte == PTYPE_HI);
            5'd3:  hdr_ok_eff = hdr_ok_reg && (data_byte == PTYPE_LO);
            5'd4:  hdr_ok_eff = hdr_ok_reg && (data_byte == HLEN);
            5'd5:  hdr_ok_eff = hdr_ok_reg && (data_byte == PLEN);
            5'd6:  hdr_ok_eff = hdr_ok_reg && (data_byte == OPCODE_HI);
            5'd7:  opcode_eff = data_byte;
            5'd8:  snode_eff  = data_byte;
            5'd9, 5'd10, 5'd11, 5'd12:
                   saddr_eff  = {saddr_reg[23:0], data_byte};
            5'd14, 5'd15, 5'd16, 5'd17:
                   tgt_ok_eff = tgt_ok_reg && (data_byte == ip_byte);
            default: ;
        endcase
    end

    // outcome on the final byte
    assign qualify = (pos_reg >= POS_LAST) && hdr_ok_eff && tgt_ok_eff;
    assign learn   = qualify && (opcode_eff == OP_REPLY) && (gw_reg == 8'd0);

    always_comb begin
        result = '0;
        if (qualify && (opcode_eff == OP_REQUEST)) begin
            result.action            = ACT_REPLY;
            result.reply_dest_node   = snode_eff;
            result.reply_target_ip   = saddr_eff;
            result.reply_sender_node = node_id;
        end else if (learn) begin
            result.action = ACT_GATEWAY;
        end
        result.gateway_node  = gw_next;
        result.gateway_known = (gw_next != 8'd0);
    end

    // next state
    always_comb begin
        pos_next    = pos_reg;
        hdr_ok_next = hdr_ok_reg;
        tgt_ok_next = tgt_ok_reg;
        opcode_next = opcode_reg;
        snode_next  = snode_reg;
        saddr_next  = saddr_reg;
        gw_next     = (last_byte && learn) ? snode_eff : gw_reg;
        if (take) begin
            opcode_next = opcode_eff;
            snode_next  = snode_eff;
            saddr_next  = saddr_eff;
            if (last_byte) begin
                pos_next    = 5'd0;
                hdr_ok_next = 1'b1;
                tgt_ok_next = 1'b1;
            end else begin
                pos_next    = (pos_reg < POS_SAT) ? pos_reg + 5'd1 : pos_reg;
                hdr_ok_next = hdr_ok_eff;
                tgt_ok_next = tgt_ok_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= 5'd0;
            hdr_ok_reg <= 1'b1;
            tgt_ok_reg <= 1'b1;
            opcode_reg <= 8'd0;
            snode_reg  <= 8'd0;
            saddr_reg  <= 32'd0;
            gw_reg     <= 8'd0;
        end else begin
            pos_reg    <= pos_next;
            hdr_ok_reg <= hdr_ok_next;
            tgt_ok_reg <= tgt_ok_next;
            opcode_reg <= opcode_next;
            snode_reg  <= snode_next;
            saddr_reg  <= saddr_next;
            if (take) begin
                gw_reg <= gw_next;
            end
        end
    end

endmodule

[hw/rtl/aar_out_stage.sv]
// Result register: holds one result word until the sink takes it.
`timescale 1ns / 1ps

module aar_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  aar_pkg::result_t result,
    output logic             free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output aar_pkg::result_t held
);
    import aar_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    // room for a new word if empty or the current one goes out now
    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign held     = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (free && load) begin
            result_reg <= result;
        end
    end

endmodule

[hw/rtl/arcnet_arp_responder_unit.sv]
// Top level of the ARCNET ARP responder.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+---------------------------------------
//  s_      | in  | s_tvalid/s_tready | tdata payload byte, tlast final byte
//  m_      | out | m_tvalid/m_tready | tuser action, tdata reply/gateway info
//  cfg_    | in  | cfg_wr_en         | cfg_addr index, cfg_wdata value
//
// One word per cycle sustained unless a final byte waits on a stalled
// result, which holds it in the input register; each byte passes that
// register and the parser, and a final byte's result is registered in the
// output register as the parser takes it. Reset (aresetn low, synchronous)
// clears the valid flags, configuration registers and parser state.
`timescale 1ns / 1ps

module arcnet_arp_responder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [7:0] reply_dest_node, [39:8] reply_target_ip,
                                   // [47:40] reply_sender_node, [55:48] gateway_node,
                                   // [56] gateway_known, [63:57] zero
    output logic [1:0]  m_tuser,   // [1:0] action
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import aar_pkg::*;

    logic [31:0] my_ip_reg;
    logic [7:0]  node_id_reg;

    in_word_t s_word;
    in_word_t p_word;
    logic     p_valid;
    logic     p_pop;
    logic     out_free;
    result_t  p_result;
    result_t  m_result;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            my_ip_reg   <= 32'd0;
            node_id_reg <= 8'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_MY_IP:   my_ip_reg   <= cfg_wdata;
                CFG_NODE_ID: node_id_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign s_word.data_byte = s_tdata;
    assign s_word.last_byte = s_tlast;

    aar_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (s_word),
        .out_valid (p_valid),
        .out_pop   (p_pop),
        .out_word  (p_word)
    );

    // a final byte waits for room in the result register
    assign p_pop = p_valid && (!p_word.last_byte || out_free);

    aar_parser u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (p_pop),
        .data_byte (p_word.data_byte),
        .last_byte (p_word.last_byte),
        .my_ip     (my_ip_reg),
        .node_id   (node_id_reg),
        .result    (p_result)
    );

    aar_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (p_pop && p_word.last_byte),
        .result   (p_result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .held     (m_result)
    );

    // pack the result word
    assign m_tuser = m_result.action;
    assign m_tdata = {7'd0,
                      m_result.gateway_known,
                      m_result.gateway_node,
                      m_result.reply_sender_node,
                      m_result.reply_target_ip,
                      m_result.reply_dest_node};

endmodule

[hw/rtl/aar_checker.sv]
// Port-level checks on the ARP responder, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aar_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        cfg_wr_en,
    input logic        cfg_addr,
    input logic [31:0] cfg_wdata
);
    import aar_pkg::*;

    // outcome code is one of the three defined actions
    `ASSERT_CLK(a_action_code, aclk, aresetn, m_tvalid |-> (m_tuser == ACT_IGNORE || m_tuser == ACT_REPLY || m_tuser == ACT_GATEWAY))

    // gateway flag tracks a nonzero gateway node
    `ASSERT_CLK(a_gw_flag, aclk, aresetn, m_tvalid |-> (m_tdata[56] == (m_tdata[55:48] != 8'd0)))

    // reply fields are zero unless a reply is requested
    `ASSERT_CLK_MSG(a_reply_zero, aclk, aresetn, (m_tvalid && m_tuser != ACT_REPLY) |-> (m_tdata[47:0] == 48'd0), "reply fields set without reply")

    // a stalled result word holds
    `ASSERT_CLK(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))

endmodule

bind arcnet_arp_responder_unit aar_checker u_aar_checker (.*);

[dv/testbench.sv]
// Self-checking testbench for the ARCNET ARP responder unit.
`timescale 1ns / 1ps

module testbench;
    import aar_pkg::*;

    // Clock, reset and block ports
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr  = CFG_MY_IP;
    logic [31:0] cfg_wdata = '0;

    // Shadow of the configuration registers
    logic [31:0] shadow_my_ip;
    logic [7:0]  shadow_node_id;

    // Shadow of the payload parser
    logic [4:0]  payload_pos;
    logic        header_ok;
    logic [7:0]  opcode_seen;
    logic [7:0]  requester_node;
    logic [31:0] requester_ip;
    logic        target_ok;
    logic [7:0]  gateway_seen;

    // Outcomes waiting for the result stream
    result_t     pending_outcomes[$];

    int error_count    = 0;
    int words_sent     = 0;
    bit sender_gaps    = 1'b0;
    bit receiver_stall = 1'b0;
    int stall_left     = 0;

    arcnet_arp_responder_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result stream backpressure: short stalls mostly, a long one now and then
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (receiver_stall && $urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result word against the oldest predicted outcome
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outcomes.size() == 0) begin
                $error("result word with no outcome pending");
                error_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (m_tuser !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, m_tuser);
                    error_count++;
                end
                if (m_tdata[7:0] !== want.reply_dest_node) begin
                    $error("reply_dest_node: expected %0h, got %0h",
                           want.reply_dest_node, m_tdata[7:0]);
                    error_count++;
                end
                if (m_tdata[39:8] !== want.reply_target_ip) begin
                    $error("reply_target_ip: expected %0h, got %0h",
                           want.reply_target_ip, m_tdata[39:8]);
                    error_count++;
                end
                if (m_tdata[47:40] !== want.reply_sender_node) begin
                    $error("reply_sender_node: expected %0h, got %0h",
                           want.reply_sender_node, m_tdata[47:40]);
                    error_count++;
                end
                if (m_tdata[55:48] !== want.gateway_node) begin
                    $error("gateway_node: expected %0h, got %0h",
                           want.gateway_node, m_tdata[55:48]);
                    error_count++;
                end
                if (m_tdata[56] !== want.gateway_known) begin
                    $error("gateway_known: expected %0d, got %0d",
                           want.gateway_known, m_tdata[56]);
                    error_count++;
                end
                if (m_tdata[63:57] !== 7'd0) begin
                    $error("tdata padding: expected 0, got %0h", m_tdata[63:57]);
                    error_count++;
                end
            end
        end
    end

    // Parser shadow: consume one accepted word, queue an outcome on the final byte
    task automatic track_payload_word(input logic [7:0] data, input logic last);
        result_t    outcome;
        logic [4:0] pos;
        pos = payload_pos;
        case (pos)
            5'd0: if (data != HTYPE_HI)  header_ok = 1'b0;
            5'd1: if (data != HTYPE_LO)  header_ok = 1'b0;
            5'd2: if (data != PTYPE_HI)  header_ok = 1'b0;
            5'd3: if (data != PTYPE_LO)  header_ok = 1'b0;
            5'd4: if (data != HLEN)      header_ok = 1'b0;
            5'd5: if (data != PLEN)      header_ok = 1'b0;
            5'd6: if (data != OPCODE_HI) header_ok = 1'b0;
            5'd7: opcode_seen = data;
            5'd8: requester_node = data;
            5'd9, 5'd10, 5'd11, 5'd12: requester_ip = {requester_ip[23:0], data};
            // target IP is compared big-endian against our address
            5'd14, 5'd15, 5'd16, 5'd17:
                if (shadow_my_ip[8 * (POS_LAST - pos) +: 8] != data) target_ok = 1'b0;
            default: ;
        endcase
        if (pos < POS_SAT) payload_pos = pos + 5'd1;
        if (last) begin
            outcome = '0;
            outcome.action = ACT_IGNORE;
            if (pos >= POS_LAST && header_ok && target_ok) begin
                if (opcode_seen == OP_REQUEST) begin
                    outcome.action            = ACT_REPLY;
                    outcome.reply_dest_node   = requester_node;
                    outcome.reply_target_ip   = requester_ip;
                    outcome.reply_sender_node = shadow_node_id;
                end else if (opcode_seen == OP_REPLY && gateway_seen == 8'd0) begin
                    outcome.action = ACT_GATEWAY;
                    gateway_seen   = requester_node;
                end
            end
            outcome.gateway_node  = gateway_seen;
            outcome.gateway_known = (gateway_seen != 8'd0);
            pending_outcomes.push_back(outcome);
            payload_pos = '0;
            header_ok   = 1'b1;
            target_ok   = 1'b1;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!sender_gaps || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Present one word and hold it until accepted
    task automatic send_word(input logic [7:0] data, input logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        track_payload_word(data, last);
        words_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Build an ARP payload and stream its first len bytes.
    // bad_at in 0..6 corrupts that header byte; noise makes every byte random.
    task automatic send_packet(input logic [7:0] op, input logic [7:0] node,
                               input logic [31:0] sip, input logic [31:0] tip,
                               input int len, input int bad_at, input bit noise);
        logic [7:0] pkt [32];
        int i;
        for (i = 0; i < 32; i++) pkt[i] = $urandom_range(0, 255);
        if (!noise) begin
            pkt[0] = HTYPE_HI;
            pkt[1] = HTYPE_LO;
            pkt[2] = PTYPE_HI;
            pkt[3] = PTYPE_LO;
            pkt[4] = HLEN;
            pkt[5] = PLEN;
            pkt[6] = OPCODE_HI;
            pkt[7] = op;
            pkt[8] = node;
            for (i = 0; i < 4; i++) begin
                pkt[9 + i]  = sip[8 * (3 - i) +: 8];
                pkt[14 + i] = tip[8 * (3 - i) +: 8];
            end
            if (bad_at >= 0 && bad_at <= 6)
                pkt[bad_at] = pkt[bad_at] ^ 8'($urandom_range(1, 255));
        end
        for (i = 0; i < len; i++) send_word(pkt[i], i == len - 1);
    endtask

    // Let every pending outcome come out, then let the pipeline settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic addr, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == CFG_MY_IP) shadow_my_ip = value;
        else shadow_node_id = value[7:0];
    endtask

    task automatic configure(input logic [31:0] ip, input logic [7:0] node);
        write_register(CFG_MY_IP, ip);
        write_register(CFG_NODE_ID, {24'd0, node});
    endtask

    task automatic apply_reset();
        shadow_my_ip   = '0;
        shadow_node_id = '0;
        payload_pos    = '0;
        header_ok      = 1'b1;
        opcode_seen    = '0;
        requester_node = '0;
        requester_ip   = '0;
        target_ok      = 1'b1;
        gateway_seen   = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
    endtask

    // Who-has requests for our address, at the extremes of every field
    task automatic test_directed_replies();
        configure(32'hFFFF_FFFF, 8'hFF);
        send_packet(OP_REQUEST, 8'hFF, 32'hFFFF_FFFF, shadow_my_ip, 18, -1, 1'b0);
        send_packet(OP_REQUEST, 8'h00, 32'h0000_0000, shadow_my_ip, 18, -1, 1'b0);
        // long packet: trailing bytes ignored, still answered
        send_packet(OP_REQUEST, 8'h5A, 32'hC0A8_0102, shadow_my_ip, 24, -1, 1'b0);
        drain_results();
        configure(32'h0000_0000, 8'h00);
        send_packet(OP_REQUEST, 8'hA5, 32'h0A00_0001, 32'h0, 18, -1, 1'b0);
        drain_results();
    endtask

    // Packets that must be ignored
    task automatic test_directed_rejects();
        configure(32'hC0A8_0001, 8'h42);
        send_packet(OP_REQUEST, 8'h11, 32'h0102_0304, shadow_my_ip, 17, -1, 1'b0);
        send_packet(OP_REQUEST, 8'h11, 32'h0102_0304, shadow_my_ip, 1, -1, 1'b0);
        send_packet(OP_REQUEST, 8'h11, 32'h0102_0304, shadow_my_ip, 18, 1, 1'b0);
        send_packet(OP_REQUEST, 8'h11, 32'h0102_0304, shadow_my_ip, 18, 6, 1'b0);
        send_packet(8'h03, 8'h11, 32'h0102_0304, shadow_my_ip, 18, -1, 1'b0);
        send_packet(OP_REQUEST, 8'h11, 32'h0102_0304, shadow_my_ip ^ 32'h100, 18, -1,
                    1'b0);
        drain_results();
    endtask

    // Gateway learning: node zero learns nothing, then first nonzero sticks
    task automatic test_directed_gateway();
        send_packet(OP_REPLY, 8'h00, 32'h0102_0304, shadow_my_ip, 18, -1, 1'b0);
        send_packet(OP_REPLY, 8'hFF, 32'h0102_0304, shadow_my_ip, 18, -1, 1'b0);
        send_packet(OP_REPLY, 8'h05, 32'h0102_0304, shadow_my_ip, 18, -1, 1'b0);
        drain_results();
    endtask

    // Mostly well-formed packets with random content, plus broken ones and noise
    task automatic send_random_packet();
        logic [7:0]  op;
        logic [31:0] tip;
        int          len, bad_at, r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            send_packet(8'h00, 8'h00, 32'h0, 32'h0, $urandom_range(1, 24), -1, 1'b1);
            return;
        end
        r  = $urandom_range(0, 99);
        op = (r < 60) ? OP_REQUEST : (r < 85) ? OP_REPLY : 8'($urandom_range(0, 255));
        r   = $urandom_range(0, 99);
        tip = (r < 75) ? shadow_my_ip
            : (r < 90) ? shadow_my_ip ^ (32'hFF << (8 * $urandom_range(0, 3)))
            : $urandom();
        r   = $urandom_range(0, 99);
        len = (r < 75) ? 18 : (r < 87) ? $urandom_range(1, 17) : $urandom_range(19, 28);
        bad_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : -1;
        send_packet(op, 8'($urandom_range(0, 255)), $urandom(), tip, len, bad_at, 1'b0);
    endtask

    // Four phases with different settings and idle patterns
    task automatic test_random_traffic();
        int phase, phase_start;
        for (phase = 0; phase < 4; phase++) begin
            case (phase % 4)
                0:       configure(32'h0000_0000, 8'h00);
                1:       configure(32'hFFFF_FFFF, 8'hFF);
                default: configure($urandom(), 8'($urandom_range(0, 255)));
            endcase
            sender_gaps    = phase[0];
            receiver_stall = phase[1];
            phase_start    = words_sent;
            while (words_sent - phase_start < 50) send_random_packet();
            drain_results();
        end
    endtask

    initial begin
        apply_reset();
        test_directed_replies();
        sender_gaps    = 1'b1;
        receiver_stall = 1'b1;
        test_directed_rejects();
        test_directed_gateway();
        test_random_traffic();
        drain_results();
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
